@@ rtl/rkt_pkg.sv @@
// Shared types and constants of the reference-counted key table.
`default_nettype none

package rkt_pkg;

  // Fixed payload widths
  localparam int KEY_W       = 32;
  localparam int REF_COUNT_W = 16;
  localparam int ACTIVE_W    = 6;

  // Operation codes carried by an input item
  typedef enum logic [1:0] {
    KIND_SUB   = 2'd0,
    KIND_UNSUB = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

endpackage

`default_nettype wire

@@ rtl/rkt_if.sv @@
// Valid/ready channel interfaces for operation items and result items.
`default_nettype none

interface rkt_in_if import rkt_pkg::*; ();
  logic               valid;
  logic               ready;
  kind_t              kind;
  logic [KEY_W-1:0]   key;

  modport source (output valid, output kind, output key, input ready);
  modport sink   (input valid, input kind, input key, output ready);
endinterface

interface rkt_out_if import rkt_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   ok;
  logic                   present;
  logic [REF_COUNT_W-1:0] ref_count;
  logic [ACTIVE_W-1:0]    active_entries;

  modport source (output valid, output ok, output present, output ref_count,
                  output active_entries, input ready);
  modport sink   (input valid, input ok, input present, input ref_count,
                  input active_entries, output ready);
endinterface

`default_nettype wire

@@ rtl/rkt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rkt_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 32,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                    clk,
  input  wire logic                    we,
  input  wire logic [AW-1:0]           waddr,
  input  wire logic [WIDTH-1:0]        wdata,
  input  wire logic [AW-1:0]           raddr,
  output      logic [WIDTH-1:0]        rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

`default_nettype wire

@@ rtl/refcounted_key_table_core.sv @@
// Top level: reference-counted key table, one entry RAM scanned per item.
// Subscribe, unsubscribe and query: accept in idle, read every entry in the scan state, then drain
// and evaluate, then update the entry and load the result together; a clear wipes every entry, then reports.
// Items go through one at a time, paced by the scan over the single read port of the entry RAM: no new
// item is accepted before the last is reported; a stalled output holds the item in its update state.
// Reset: a wipe pass zeroes every entry; no item is accepted until it ends.
`default_nettype none

module refcounted_key_table_core import rkt_pkg::*; #(
  parameter int CAPACITY   = 32,
  parameter int COUNT_BITS = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  rkt_in_if.sink     in_ch,
  rkt_out_if.source  out_ch
);
  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OCC_W  = $clog2(CAPACITY + 1);
  localparam int WORD_W = KEY_W + COUNT_BITS;
  localparam logic [IDX_W-1:0]      LAST_IDX  = IDX_W'(CAPACITY - 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [2:0] {
    ST_WIPE,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE
  } state_t;

  state_t                state_r, state_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic                  rd_valid_r, rd_valid_nxt;
  logic [IDX_W-1:0]      rd_idx_r, rd_idx_nxt;
  kind_t                 op_kind_r, op_kind_nxt;
  logic [KEY_W-1:0]      op_key_r, op_key_nxt;
  logic                  hit_r, hit_nxt;
  logic [IDX_W-1:0]      hit_idx_r, hit_idx_nxt;
  logic [COUNT_BITS-1:0] hit_cnt_r, hit_cnt_nxt;
  logic                  free_r, free_nxt;
  logic [IDX_W-1:0]      free_idx_r, free_idx_nxt;
  logic [OCC_W-1:0]      occ_r, occ_nxt;
  logic                  clr_report_r, clr_report_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_ok_r, out_ok_nxt;
  logic                  out_present_r, out_present_nxt;
  logic [COUNT_BITS-1:0] out_cnt_r, out_cnt_nxt;
  logic [OCC_W-1:0]      out_occ_r, out_occ_nxt;

  // Entry RAM port signals
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [WORD_W-1:0]     ram_wdata;
  logic [WORD_W-1:0]     ram_rdata;
  logic [KEY_W-1:0]      rd_key;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic                  rd_live;
  logic                  out_free;
  logic [COUNT_BITS-1:0] cnt_inc, cnt_dec;

  // Entry word: key above count; a zero count marks a free entry
  rkt_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CAPACITY)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  assign rd_key   = ram_rdata[WORD_W-1:COUNT_BITS];
  assign rd_cnt   = ram_rdata[COUNT_BITS-1:0];
  assign rd_live  = (rd_cnt != '0);
  assign out_free = !out_valid_r || out_ch.ready;
  assign cnt_inc  = hit_cnt_r + COUNT_BITS'(1);
  assign cnt_dec  = hit_cnt_r - COUNT_BITS'(1);

  // Sequencer: wipe, scan, evaluate, update, report
  always_comb begin
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    rd_valid_nxt    = 1'b0;
    rd_idx_nxt      = rd_idx_r;
    op_kind_nxt     = op_kind_r;
    op_key_nxt      = op_key_r;
    hit_nxt         = hit_r;
    hit_idx_nxt     = hit_idx_r;
    hit_cnt_nxt     = hit_cnt_r;
    free_nxt        = free_r;
    free_idx_nxt    = free_idx_r;
    occ_nxt         = occ_r;
    clr_report_nxt  = clr_report_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_ok_nxt      = out_ok_r;
    out_present_nxt = out_present_r;
    out_cnt_nxt     = out_cnt_r;
    out_occ_nxt     = out_occ_r;
    ram_we          = 1'b0;
    ram_waddr       = idx_r;
    ram_wdata       = '0;

    // Compare the word read in the previous cycle
    if (rd_valid_r) begin
      if (rd_live && rd_key == op_key_r && !hit_r) begin
        hit_nxt     = 1'b1;
        hit_idx_nxt = rd_idx_r;
        hit_cnt_nxt = rd_cnt;
      end
      if (!rd_live && !free_r) begin
        free_nxt     = 1'b1;
        free_idx_nxt = rd_idx_r;
      end
    end

    unique case (state_r)
      ST_WIPE: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = '0;
        if (idx_r == LAST_IDX) begin
          idx_nxt   = '0;
          state_nxt = clr_report_r ? ST_DECIDE : ST_IDLE;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      ST_IDLE: begin
        if (in_ch.valid) begin
          op_kind_nxt = in_ch.kind;
          op_key_nxt  = in_ch.key;
          hit_nxt     = 1'b0;
          free_nxt    = 1'b0;
          idx_nxt     = '0;
          if (in_ch.kind == KIND_CLEAR) begin
            occ_nxt        = '0;
            clr_report_nxt = 1'b1;
            state_nxt      = ST_WIPE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        rd_valid_nxt = 1'b1;
        rd_idx_nxt   = idx_r;
        if (idx_r == LAST_IDX) begin
          idx_nxt   = '0;
          state_nxt = ST_DRAIN;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        // Update the entry and load the result together once the output is free
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_ok_nxt      = 1'b0;
          out_present_nxt = 1'b0;
          out_cnt_nxt     = '0;
          clr_report_nxt  = 1'b0;
          state_nxt       = ST_IDLE;
          case (op_kind_r)
            KIND_SUB: begin
              if (hit_r) begin
                out_present_nxt = 1'b1;
                if (hit_cnt_r != COUNT_MAX) begin
                  ram_we      = 1'b1;
                  ram_waddr   = hit_idx_r;
                  ram_wdata   = {op_key_r, cnt_inc};
                  out_ok_nxt  = 1'b1;
                  out_cnt_nxt = cnt_inc;
                end else begin
                  out_cnt_nxt = hit_cnt_r;
                end
              end else if (op_key_r != '0 && free_r) begin
                ram_we          = 1'b1;
                ram_waddr       = free_idx_r;
                ram_wdata       = {op_key_r, COUNT_BITS'(1)};
                occ_nxt         = occ_r + OCC_W'(1);
                out_ok_nxt      = 1'b1;
                out_present_nxt = 1'b1;
                out_cnt_nxt     = COUNT_BITS'(1);
              end
            end
            KIND_UNSUB: begin
              if (hit_r) begin
                ram_we          = 1'b1;
                ram_waddr       = hit_idx_r;
                ram_wdata       = {op_key_r, cnt_dec};
                out_ok_nxt      = 1'b1;
                out_present_nxt = (cnt_dec != '0);
                out_cnt_nxt     = cnt_dec;
                if (cnt_dec == '0) begin
                  occ_nxt = occ_r - OCC_W'(1);
                end
              end
            end
            KIND_QUERY: begin
              out_present_nxt = hit_r;
              out_cnt_nxt     = hit_r ? hit_cnt_r : '0;
            end
            KIND_CLEAR: begin
              out_ok_nxt = 1'b1;
            end
            default: begin
              out_ok_nxt = 1'b0;
            end
          endcase
          out_occ_nxt = (op_kind_r == KIND_CLEAR) ? '0 : occ_nxt;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_WIPE;
      idx_r        <= '0;
      rd_valid_r   <= 1'b0;
      hit_r        <= 1'b0;
      free_r       <= 1'b0;
      occ_r        <= '0;
      clr_report_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      rd_valid_r   <= rd_valid_nxt;
      hit_r        <= hit_nxt;
      free_r       <= free_nxt;
      occ_r        <= occ_nxt;
      clr_report_r <= clr_report_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    rd_idx_r      <= rd_idx_nxt;
    op_kind_r     <= op_kind_nxt;
    op_key_r      <= op_key_nxt;
    hit_idx_r     <= hit_idx_nxt;
    hit_cnt_r     <= hit_cnt_nxt;
    free_idx_r    <= free_idx_nxt;
    out_ok_r      <= out_ok_nxt;
    out_present_r <= out_present_nxt;
    out_cnt_r     <= out_cnt_nxt;
    out_occ_r     <= out_occ_nxt;
  end

  // Port drive; counts masked to the port widths
  logic [COUNT_BITS+REF_COUNT_W-1:0] cnt_ext;
  logic [OCC_W+ACTIVE_W-1:0]         occ_ext;

  assign cnt_ext = {{REF_COUNT_W{1'b0}}, out_cnt_r};
  assign occ_ext = {{ACTIVE_W{1'b0}}, out_occ_r};

  assign in_ch.ready           = (state_r == ST_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.ok             = out_ok_r;
  assign out_ch.present        = out_present_r;
  assign out_ch.ref_count      = cnt_ext[REF_COUNT_W-1:0];
  assign out_ch.active_entries = occ_ext[ACTIVE_W-1:0];
endmodule

`default_nettype wire

@@ tb/refcounted_key_table_core_tb.sv @@
// Self-checking testbench for the reference-counted key table core.
`timescale 1ns / 100ps

module refcounted_key_table_core_tb import rkt_pkg::*; ();

  // Table geometry under test, at the block's standard sizes
  localparam int          TABLE_SLOTS = 32;
  localparam int          REF_BITS    = 16;
  localparam int unsigned REF_LIMIT   = (1 << REF_BITS) - 1;
  localparam int          POOL_SIZE   = 40;
  localparam int          RAMP_OPS    = 40;

  typedef struct {
    logic                   ok;
    logic                   present;
    logic [REF_COUNT_W-1:0] ref_count;
    logic [ACTIVE_W-1:0]    active_entries;
  } table_reply_t;

  // Shadow key table plus the queue of replies still owed by the block
  class key_table_scoreboard;
    bit               slot_used [TABLE_SLOTS];
    logic [KEY_W-1:0] slot_key  [TABLE_SLOTS];
    int unsigned      slot_refs [TABLE_SLOTS];
    int unsigned      used_slots;
    table_reply_t     due_replies[$];
    int unsigned      mismatches;

    function new();
      wipe();
      mismatches = 0;
    endfunction

    function void wipe();
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        slot_used[i] = 1'b0;
        slot_key[i]  = '0;
        slot_refs[i] = 0;
      end
      used_slots = 0;
    endfunction

    // Slot holding the key, TABLE_SLOTS if none; key zero never matches
    function int find_slot(logic [KEY_W-1:0] key);
      if (key == '0) return TABLE_SLOTS;
      for (int i = 0; i < TABLE_SLOTS; i++)
        if (slot_used[i] && slot_key[i] == key) return i;
      return TABLE_SLOTS;
    endfunction

    function int lowest_free_slot();
      for (int i = 0; i < TABLE_SLOTS; i++)
        if (!slot_used[i]) return i;
      return TABLE_SLOTS;
    endfunction

    // Apply one accepted operation and queue the reply it must produce
    function void note_op(kind_t kind, logic [KEY_W-1:0] key);
      table_reply_t reply;
      int           s;
      reply.ok = 1'b0;
      case (kind)
        KIND_CLEAR: begin
          wipe();
          reply.ok = 1'b1;
        end
        KIND_SUB: begin
          if (key != '0) begin
            s = find_slot(key);
            if (s < TABLE_SLOTS) begin
              // saturated count: refuse, entry untouched
              if (slot_refs[s] < REF_LIMIT) begin
                slot_refs[s]++;
                reply.ok = 1'b1;
              end
            end else begin
              s = lowest_free_slot();
              if (s < TABLE_SLOTS) begin
                slot_used[s] = 1'b1;
                slot_key[s]  = key;
                slot_refs[s] = 1;
                used_slots++;
                reply.ok = 1'b1;
              end
            end
          end
        end
        KIND_UNSUB: begin
          s = find_slot(key);
          if (s < TABLE_SLOTS) begin
            if (slot_refs[s] > 0) slot_refs[s]--;
            if (slot_refs[s] == 0) begin
              slot_used[s] = 1'b0;
              slot_key[s]  = '0;
              if (used_slots > 0) used_slots--;
            end
            reply.ok = 1'b1;
          end
        end
        default: ;
      endcase

      s = (kind == KIND_CLEAR) ? TABLE_SLOTS : find_slot(key);
      if (s < TABLE_SLOTS && slot_refs[s] > 0) begin
        reply.present   = 1'b1;
        reply.ref_count = slot_refs[s][REF_COUNT_W-1:0];
      end else begin
        reply.present   = 1'b0;
        reply.ref_count = '0;
      end
      reply.active_entries = used_slots[ACTIVE_W-1:0];
      due_replies.push_back(reply);
    endfunction

    function void check_reply(table_reply_t got);
      table_reply_t want;
      if (due_replies.size() == 0) begin
        $error("result item with no operation outstanding");
        mismatches++;
        return;
      end
      want = due_replies.pop_front();
      if (got.ok !== want.ok) begin
        $error("ok: expected %0d, got %0d", want.ok, got.ok);
        mismatches++;
      end
      if (got.present !== want.present) begin
        $error("present: expected %0d, got %0d", want.present, got.present);
        mismatches++;
      end
      if (got.ref_count !== want.ref_count) begin
        $error("ref_count: expected %0d, got %0d", want.ref_count, got.ref_count);
        mismatches++;
      end
      if (got.active_entries !== want.active_entries) begin
        $error("active_entries: expected %0d, got %0d",
               want.active_entries, got.active_entries);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  rkt_in_if  in_ch ();
  rkt_out_if out_ch ();

  refcounted_key_table_core #(
    .CAPACITY   (TABLE_SLOTS),
    .COUNT_BITS (REF_BITS)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  key_table_scoreboard sb = new();

  logic [KEY_W-1:0] key_pool [POOL_SIZE];
  int unsigned      send_idle_pct  = 0;
  int unsigned      recv_stall_pct = 0;
  int unsigned      hold_req       = 0;
  int unsigned      issued         = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit
  initial begin
    #10ms;
    $display("[refcounted_key_table_core] ERROR");
    $finish;
  end

  // Result side: check accepted items, then pick next ready
  initial begin : result_sink
    int unsigned  hold_left;
    table_reply_t got;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        got.ok             = out_ch.ok;
        got.present        = out_ch.present;
        got.ref_count      = out_ch.ref_count;
        got.active_entries = out_ch.active_entries;
        sb.check_reply(got);
      end
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Offer one item; valid stays high afterwards so back-to-back items need no gap
  task automatic send_op(input kind_t kind, input logic [KEY_W-1:0] key);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind  <= kind;
    in_ch.key   <= key;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_op(kind, key);
    issued++;
  endtask

  // Stop offering and wait until every owed reply has arrived
  task automatic drain_replies();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.due_replies.size() != 0);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    if (r < 8) return $urandom;
    return key_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  function automatic kind_t pick_kind();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return KIND_SUB;
    if (r < 75) return KIND_UNSUB;
    if (r < 97) return KIND_QUERY;
    return KIND_CLEAR;
  endfunction

  task automatic run_mixed(input int unsigned count);
    repeat (count) send_op(pick_kind(), pick_key());
  endtask

  // More distinct keys than slots: the table fills and late subscribes fail
  task automatic run_fill();
    int unsigned base;
    base = $urandom_range(0, POOL_SIZE - 1);
    for (int i = 0; i < TABLE_SLOTS + 4; i++)
      send_op(KIND_SUB, key_pool[(base + i) % POOL_SIZE]);
    for (int i = 0; i < TABLE_SLOTS + 4; i++)
      if ($urandom_range(0, 1)) send_op(KIND_UNSUB, key_pool[(base + i) % POOL_SIZE]);
  endtask

  // Raise one key's count well above one, then release it past zero
  task automatic run_saturate();
    logic [KEY_W-1:0] k;
    k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    repeat (RAMP_OPS) send_op(KIND_SUB, k);
    send_op(KIND_QUERY, k);
    repeat (RAMP_OPS + 2) send_op(KIND_UNSUB, k);
  endtask

  task automatic run_random_until(input int unsigned target);
    int unsigned r;
    while (issued < target) begin
      r = $urandom_range(0, 99);
      if (r < 80)      run_mixed($urandom_range(8, 30));
      else if (r < 92) run_fill();
      else if (r < 96) run_saturate();
      else             send_op(KIND_CLEAR, $urandom);
    end
  endtask

  initial begin : stimulus
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.kind  <= KIND_SUB;
    in_ch.key   <= '0;

    // Distinct nonzero keys: low bits carry the index, upper bits random
    for (int i = 0; i < POOL_SIZE - 1; i++)
      key_pool[i] = ($urandom << 6) | (i + 1);
    key_pool[POOL_SIZE - 1] = '1;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: key zero, absent keys, extreme keys, slot reuse, clear
    send_op(KIND_QUERY, '0);
    send_op(KIND_SUB,   '0);
    send_op(KIND_UNSUB, '0);
    send_op(KIND_UNSUB, 32'hFFFF_FFFF);
    send_op(KIND_SUB,   32'hFFFF_FFFF);
    send_op(KIND_SUB,   32'hFFFF_FFFF);
    send_op(KIND_SUB,   32'h0000_0001);
    send_op(KIND_SUB,   32'h8000_0000);
    send_op(KIND_QUERY, 32'hFFFF_FFFF);
    send_op(KIND_QUERY, 32'h0000_0001);
    send_op(KIND_QUERY, 32'h5A5A_5A5A);
    send_op(KIND_UNSUB, 32'hFFFF_FFFF);
    send_op(KIND_UNSUB, 32'h0000_0001);
    send_op(KIND_SUB,   32'h0000_0002);
    send_op(KIND_QUERY, '0);
    send_op(KIND_CLEAR, 32'h0000_0002);
    send_op(KIND_QUERY, 32'hFFFF_FFFF);
    send_op(KIND_UNSUB, 32'h8000_0000);
    // Table full and a deep count ramp, each at least once
    run_fill();
    send_op(KIND_CLEAR, '0);
    run_saturate();
    drain_replies();

    // Sender idles most cycles
    send_idle_pct  = 75;
    recv_stall_pct = 0;
    run_random_until(450);
    drain_replies();

    // Receiver stalls most cycles
    send_idle_pct  = 0;
    recv_stall_pct = 75;
    run_random_until(700);
    drain_replies();

    // Light idling on both sides
    send_idle_pct  = 17;
    recv_stall_pct = 17;
    run_random_until(950);
    drain_replies();

    // Full rate; receiver holds off a long stretch so the input backs up
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 500;
    run_random_until(1100);
    drain_replies();

    repeat (60) @(posedge clk);
    if (sb.mismatches == 0 && sb.due_replies.size() == 0) begin
      $display("[refcounted_key_table_core] OK");
    end else begin
      $display("[refcounted_key_table_core] ERROR");
    end
    $finish;
  end

endmodule
